[hw/rtl/multilevel_run_queue_scheduler_defines.svh]
// Assertion macros for the run-queue scheduler.
`ifndef MULTILEVEL_RUN_QUEUE_SCHEDULER_DEFINES_SVH
`define MULTILEVEL_RUN_QUEUE_SCHEDULER_DEFINES_SVH

`ifndef SYNTH
`define MRQS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define MRQS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define MRQS_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define MRQS_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/mrqs_pkg.sv]
// Shared types and constants of the run-queue scheduler.
`timescale 1ns / 1ps
package mrqs_pkg;

  localparam logic OP_ENQUEUE  = 1'b0;
  localparam logic OP_SCHEDULE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_AP_WR, S_RT, S_POP_CHK, S_POP_LNK, S_POL,
    S_ME_INIT, S_ME_CHK, S_ME_Q, S_ME_ADV, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_ENQ_SETUP, CMD_AP_WRITE, CMD_REQ_EXP, CMD_RT_POP,
    CMD_POL_INIT, CMD_POL_STEP, CMD_ME_INIT, CMD_ME_RD, CMD_ME_Q, CMD_ME_ADV,
    CMD_ME_END, CMD_POP_CHK, CMD_POP_LNK, CMD_RESULT
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
  } ctrl_cmd_t;

  typedef struct packed {
    logic op_sched;
    logic tid_ok;
    logic run_flag;
    logic pol_rt;
    logic rt_hit;
    logic pol_hit;
    logic exp_ne;
    logic last_miss;
    logic more_pol;
    logic head_eq_tail;
    logic me_more;
    logic out_free;
  } dp_status_t;

endpackage

[hw/rtl/multilevel_run_queue_scheduler.sv]
// Top level of the run-queue scheduler.
`timescale 1ns / 1ps
// One CPU's run-queue engine: FIFO queues per policy and priority kept as
// linked lists in thread-indexed tables. An enqueue transaction gives no
// result; a schedule transaction gives one result, soonest on a real-time
// hit and latest when every round of every policy is tried and expired
// lists are walked, one expired thread at a time. One transaction is in
// flight at a time; a finished result waits in the output register.
module multilevel_run_queue_scheduler #(
  parameter int THREAD_SLOTS    = 64,
  parameter int PRIORITY_LEVELS = 32,
  parameter int POLICY_COUNT    = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // thread_id, thread_policy, thread_priority, prev_running
  input  logic [0:0]  in_tuser,  // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata  // next_thread, found
);

  mrqs_pkg::ctrl_cmd_t  cmd;
  mrqs_pkg::dp_status_t st;
  logic [5:0]           next_thread;
  logic                 found;

  mrqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  mrqs_datapath #(
    .THREAD_SLOTS    (THREAD_SLOTS),
    .PRIORITY_LEVELS (PRIORITY_LEVELS),
    .POLICY_COUNT    (POLICY_COUNT)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_opcode          (in_tuser[0]),
    .in_thread_id       (in_tdata[5:0]),
    .in_thread_policy   (in_tdata[7:6]),
    .in_thread_priority (in_tdata[12:8]),
    .in_prev_running    (in_tdata[13]),
    .cmd                (cmd),
    .st                 (st),
    .out_tready         (out_tready),
    .out_tvalid         (out_tvalid),
    .out_next_thread    (next_thread),
    .out_found          (found)
  );

  assign out_tdata = {1'b0, found, next_thread};

endmodule

[hw/rtl/mrqs_ctrl.sv]
// Sequencing state machine of the run-queue scheduler.
`timescale 1ns / 1ps
`include "multilevel_run_queue_scheduler_defines.svh"
module mrqs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  mrqs_pkg::dp_status_t st,
  output mrqs_pkg::ctrl_cmd_t  cmd
);

  mrqs_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mrqs_pkg::S_IDLE;
      ret_r   <= mrqs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    case (state_r)
      mrqs_pkg::S_IDLE: if (in_tvalid) state_nxt = mrqs_pkg::S_DECODE;
      mrqs_pkg::S_DECODE: begin
        if (!st.op_sched) begin
          state_nxt = st.tid_ok ? mrqs_pkg::S_AP_WR : mrqs_pkg::S_IDLE;
          ret_nxt   = mrqs_pkg::S_IDLE;
        end else if (st.run_flag && st.tid_ok && st.pol_rt) begin
          state_nxt = mrqs_pkg::S_AP_WR;
          ret_nxt   = mrqs_pkg::S_RT;
        end else begin
          state_nxt = mrqs_pkg::S_RT;
        end
      end
      mrqs_pkg::S_AP_WR:   state_nxt = ret_r;
      mrqs_pkg::S_RT:      state_nxt = st.rt_hit ? mrqs_pkg::S_POP_CHK : mrqs_pkg::S_POL;
      mrqs_pkg::S_POP_CHK: state_nxt = st.head_eq_tail ? mrqs_pkg::S_DONE : mrqs_pkg::S_POP_LNK;
      mrqs_pkg::S_POP_LNK: state_nxt = mrqs_pkg::S_DONE;
      mrqs_pkg::S_POL: begin
        if (st.pol_hit)                        state_nxt = mrqs_pkg::S_POP_CHK;
        else if (st.exp_ne)                    state_nxt = mrqs_pkg::S_ME_INIT;
        else if (st.last_miss && !st.more_pol) state_nxt = mrqs_pkg::S_DONE;
      end
      mrqs_pkg::S_ME_INIT: state_nxt = mrqs_pkg::S_ME_CHK;
      mrqs_pkg::S_ME_CHK:  state_nxt = st.me_more ? mrqs_pkg::S_ME_Q : mrqs_pkg::S_POL;
      mrqs_pkg::S_ME_Q: begin
        state_nxt = mrqs_pkg::S_AP_WR;
        ret_nxt   = mrqs_pkg::S_ME_ADV;
      end
      mrqs_pkg::S_ME_ADV:  state_nxt = mrqs_pkg::S_ME_CHK;
      mrqs_pkg::S_DONE:    if (st.out_free) state_nxt = mrqs_pkg::S_IDLE;
      default:             state_nxt = mrqs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.cmd   = mrqs_pkg::CMD_NONE;
    in_tready = 1'b0;
    case (state_r)
      mrqs_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd.cmd = mrqs_pkg::CMD_LOAD;
      end
      mrqs_pkg::S_DECODE: begin
        if (st.tid_ok && (!st.op_sched || (st.run_flag && st.pol_rt)))
          cmd.cmd = mrqs_pkg::CMD_ENQ_SETUP;
        else if (st.op_sched && st.run_flag && st.tid_ok)
          cmd.cmd = mrqs_pkg::CMD_REQ_EXP;
      end
      mrqs_pkg::S_AP_WR:   cmd.cmd = mrqs_pkg::CMD_AP_WRITE;
      mrqs_pkg::S_RT:      cmd.cmd = st.rt_hit ? mrqs_pkg::CMD_RT_POP : mrqs_pkg::CMD_POL_INIT;
      mrqs_pkg::S_POP_CHK: cmd.cmd = mrqs_pkg::CMD_POP_CHK;
      mrqs_pkg::S_POP_LNK: cmd.cmd = mrqs_pkg::CMD_POP_LNK;
      mrqs_pkg::S_POL:     cmd.cmd = mrqs_pkg::CMD_POL_STEP;
      mrqs_pkg::S_ME_INIT: cmd.cmd = mrqs_pkg::CMD_ME_INIT;
      mrqs_pkg::S_ME_CHK:  cmd.cmd = st.me_more ? mrqs_pkg::CMD_ME_RD : mrqs_pkg::CMD_ME_END;
      mrqs_pkg::S_ME_Q:    cmd.cmd = mrqs_pkg::CMD_ME_Q;
      mrqs_pkg::S_ME_ADV:  cmd.cmd = mrqs_pkg::CMD_ME_ADV;
      mrqs_pkg::S_DONE:    if (st.out_free) cmd.cmd = mrqs_pkg::CMD_RESULT;
      default:             cmd.cmd = mrqs_pkg::CMD_NONE;
    endcase
  end

  `MRQS_ASSERT_NXT(a_accept_decode, clk, rst_n, in_tvalid && in_tready, state_r == mrqs_pkg::S_DECODE)
  `MRQS_ASSERT_IMP(a_append_src, clk, rst_n, state_r == mrqs_pkg::S_AP_WR, $past(state_r) == mrqs_pkg::S_DECODE || $past(state_r) == mrqs_pkg::S_ME_Q)
  `MRQS_ASSERT_IMP(a_link_src, clk, rst_n, state_r == mrqs_pkg::S_POP_LNK, $past(state_r) == mrqs_pkg::S_POP_CHK)

endmodule

[hw/rtl/mrqs_datapath.sv]
// Queue tables, search logic and result register of the run-queue scheduler.
`timescale 1ns / 1ps
module mrqs_datapath #(
  parameter int THREAD_SLOTS    = 64,
  parameter int PRIORITY_LEVELS = 32,
  parameter int POLICY_COUNT    = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_opcode,
  input  logic [5:0]           in_thread_id,
  input  logic [1:0]           in_thread_policy,
  input  logic [4:0]           in_thread_priority,
  input  logic                 in_prev_running,
  input  mrqs_pkg::ctrl_cmd_t  cmd,
  output mrqs_pkg::dp_status_t st,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic [5:0]           out_next_thread,
  output logic                 out_found
);

  localparam int PL   = PRIORITY_LEVELS;
  localparam int PC   = POLICY_COUNT;
  localparam int QN   = PC * PL;
  localparam int QW   = $clog2(QN);
  localparam int PW   = $clog2(PL);
  localparam int POLW = $clog2(PC);
  localparam int IDW  = $clog2(THREAD_SLOTS);
  localparam int CW   = $clog2(THREAD_SLOTS + 1);
  localparam int EN   = PC - 1;
  localparam int EW   = (EN > 1) ? $clog2(EN) : 1;

  function automatic logic [QW-1:0] queue_of(input logic [POLW-1:0] pol,
                                             input logic [PW-1:0] pri);
    logic [POLW-1:0] cp;
    logic [PW-1:0]   cr;
    cp = (int'(pol) >= PC) ? POLW'(PC - 1) : pol;
    cr = (int'(pri) >= PL) ? PW'(PL - 1) : pri;
    return QW'(int'(cp) * PL + int'(cr));
  endfunction

  mrqs_pkg::cmd_t c;
  assign c = cmd.cmd;

  // request
  logic            req_op_r, req_run_r, req_ok_r;
  logic [IDW-1:0]  req_tid_r;
  logic [POLW-1:0] req_pol_r;
  logic [PW-1:0]   req_pri_r;
  logic [QW-1:0]   req_q;
  logic [EW-1:0]   req_e;

  // tables
  logic [IDW-1:0]  head_mem [QN];
  logic [IDW-1:0]  tail_mem [QN];
  logic [IDW-1:0]  link_mem [THREAD_SLOTS];
  logic [POLW-1:0] spol_mem [THREAD_SLOTS];
  logic [PW-1:0]   spri_mem [THREAD_SLOTS];
  logic [IDW-1:0]  head_rd_r, tail_rd_r, link_rd_r;
  logic [POLW-1:0] spol_rd_r;
  logic [PW-1:0]   spri_rd_r;
  logic [QN-1:0]   ne_r;

  logic [IDW-1:0]  exp_head_r [EN];
  logic [CW-1:0]   exp_cnt_r  [EN];
  logic [EN-1:0]   exp_ne_r;
  logic [PW-1:0]   round_r    [EN];

  // walk and search registers
  logic [POLW-1:0] cur_pol_r;
  logic [EW-1:0]   cur_e;
  logic [PW-1:0]   miss_r;
  logic [IDW-1:0]  me_cur_r, me_nxt_r;
  logic [CW-1:0]   me_i_r;
  logic [IDW-1:0]  ap_t_r;
  logic [QW-1:0]   ap_q_r, pop_q_r, slot_q;
  logic            out_valid_r, found_r, out_found_r;
  logic [5:0]      next_r, out_next_r;

  // search results
  logic            rt_hit, pol_hit;
  logic [PW-1:0]   rt_p, pol_p;
  logic [QW-1:0]   rt_q, pol_q, qi;

  assign req_q  = queue_of(req_pol_r, req_pri_r);
  assign req_e  = EW'(int'(req_pol_r) - 1);
  assign cur_e  = EW'(int'(cur_pol_r) - 1);
  assign slot_q = queue_of(spol_rd_r, spri_rd_r);

  always_comb begin
    rt_hit = 1'b0;
    rt_p   = '0;
    for (int p = 0; p < PL; p++) begin
      if (ne_r[p]) begin
        rt_hit = 1'b1;
        rt_p   = PW'(p);
      end
    end
  end
  assign rt_q = QW'(rt_p);

  always_comb begin
    pol_hit = 1'b0;
    pol_p   = '0;
    qi      = '0;
    for (int p = 0; p < PL; p++) begin
      qi = QW'(int'(cur_pol_r) * PL + p);
      if (ne_r[qi] && !((cur_pol_r == POLW'(1)) && (round_r[0] > PW'(p)))) begin
        pol_hit = 1'b1;
        pol_p   = PW'(p);
      end
    end
  end
  assign pol_q = queue_of(cur_pol_r, pol_p);

  // request capture
  always_ff @(posedge clk) begin
    if (c == mrqs_pkg::CMD_LOAD) begin
      req_op_r  <= in_opcode;
      req_run_r <= in_prev_running;
      req_ok_r  <= int'(in_thread_id) < THREAD_SLOTS;
      req_tid_r <= IDW'(in_thread_id);
      req_pol_r <= (int'(in_thread_policy) >= PC) ? POLW'(PC - 1) : POLW'(in_thread_policy);
      req_pri_r <= (int'(in_thread_priority) >= PL) ? PW'(PL - 1) : PW'(in_thread_priority);
    end
  end

  // table read addresses
  logic [QW-1:0]  ht_raddr;
  logic [IDW-1:0] link_raddr;
  always_comb begin
    case (c)
      mrqs_pkg::CMD_ENQ_SETUP: ht_raddr = req_q;
      mrqs_pkg::CMD_ME_Q:      ht_raddr = slot_q;
      mrqs_pkg::CMD_RT_POP:    ht_raddr = rt_q;
      default:                 ht_raddr = pol_q;
    endcase
    link_raddr = (c == mrqs_pkg::CMD_POP_CHK) ? head_rd_r : me_cur_r;
  end

  // table writes
  logic           link_we, tail_we, head_we, slot_we;
  logic [IDW-1:0] link_wa, link_wd, head_wd;
  logic [QW-1:0]  head_wa;
  always_comb begin
    link_we = 1'b0;
    link_wa = tail_rd_r;
    link_wd = ap_t_r;
    head_we = 1'b0;
    head_wa = ap_q_r;
    head_wd = ap_t_r;
    tail_we = (c == mrqs_pkg::CMD_AP_WRITE);
    slot_we = (c == mrqs_pkg::CMD_ENQ_SETUP) || (c == mrqs_pkg::CMD_REQ_EXP);
    case (c)
      mrqs_pkg::CMD_AP_WRITE: begin
        link_we = ne_r[ap_q_r];
        head_we = !ne_r[ap_q_r];
      end
      mrqs_pkg::CMD_REQ_EXP: begin
        link_we = exp_ne_r[req_e];
        link_wa = req_tid_r;
        link_wd = exp_head_r[req_e];
      end
      mrqs_pkg::CMD_POP_LNK: begin
        head_we = 1'b1;
        head_wa = pop_q_r;
        head_wd = link_rd_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (tail_we) tail_mem[ap_q_r] <= ap_t_r;
    if (link_we) link_mem[link_wa] <= link_wd;
    if (slot_we) begin
      spol_mem[req_tid_r] <= req_pol_r;
      spri_mem[req_tid_r] <= req_pri_r;
    end
    head_rd_r <= head_mem[ht_raddr];
    tail_rd_r <= tail_mem[ht_raddr];
    link_rd_r <= link_mem[link_raddr];
    spol_rd_r <= spol_mem[me_cur_r];
    spri_rd_r <= spri_mem[me_cur_r];
  end

  // payload registers of the walk, pop and result
  always_ff @(posedge clk) begin
    case (c)
      mrqs_pkg::CMD_ENQ_SETUP: begin
        ap_t_r <= req_tid_r;
        ap_q_r <= req_q;
      end
      mrqs_pkg::CMD_RT_POP: pop_q_r <= rt_q;
      mrqs_pkg::CMD_POL_STEP: begin
        if (pol_hit) pop_q_r <= pol_q;
        else if (!exp_ne_r[cur_e] && (miss_r == PW'(PL - 1)) && (cur_pol_r == POLW'(PC - 1))) begin
          next_r  <= '0;
          found_r <= 1'b0;
        end
      end
      mrqs_pkg::CMD_ME_INIT: begin
        me_cur_r <= exp_head_r[cur_e];
        me_i_r   <= '0;
      end
      mrqs_pkg::CMD_ME_Q: begin
        me_nxt_r <= link_rd_r;
        ap_t_r   <= me_cur_r;
        ap_q_r   <= slot_q;
      end
      mrqs_pkg::CMD_ME_ADV: begin
        me_cur_r <= me_nxt_r;
        me_i_r   <= me_i_r + CW'(1);
      end
      mrqs_pkg::CMD_POP_CHK: begin
        next_r  <= 6'(head_rd_r);
        found_r <= 1'b1;
      end
      mrqs_pkg::CMD_RESULT: begin
        out_next_r  <= next_r;
        out_found_r <= found_r;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ne_r        <= '0;
      exp_ne_r    <= '0;
      out_valid_r <= 1'b0;
      cur_pol_r   <= POLW'(1);
      miss_r      <= '0;
      for (int e = 0; e < EN; e++) begin
        exp_cnt_r[e] <= '0;
        round_r[e]   <= PW'(PL - 1);
      end
    end else begin
      if (c == mrqs_pkg::CMD_RESULT) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (c)
        mrqs_pkg::CMD_AP_WRITE: ne_r[ap_q_r] <= 1'b1;
        mrqs_pkg::CMD_REQ_EXP: begin
          exp_head_r[req_e] <= req_tid_r;
          exp_ne_r[req_e]   <= 1'b1;
          if (exp_cnt_r[req_e] < CW'(THREAD_SLOTS))
            exp_cnt_r[req_e] <= exp_cnt_r[req_e] + CW'(1);
        end
        mrqs_pkg::CMD_POP_CHK: if (head_rd_r == tail_rd_r) ne_r[pop_q_r] <= 1'b0;
        mrqs_pkg::CMD_POL_INIT: begin
          cur_pol_r <= POLW'(1);
          miss_r    <= '0;
        end
        mrqs_pkg::CMD_POL_STEP: begin
          if (!pol_hit) begin
            round_r[cur_e] <= (round_r[cur_e] == '0) ? PW'(PL - 1) : round_r[cur_e] - PW'(1);
            if (!exp_ne_r[cur_e]) begin
              if (miss_r == PW'(PL - 1)) begin
                miss_r <= '0;
                if (cur_pol_r != POLW'(PC - 1)) cur_pol_r <= cur_pol_r + POLW'(1);
              end else begin
                miss_r <= miss_r + PW'(1);
              end
            end
          end
        end
        mrqs_pkg::CMD_ME_END: begin
          exp_ne_r[cur_e]  <= 1'b0;
          exp_cnt_r[cur_e] <= '0;
        end
        default: ;
      endcase
    end
  end

  assign st.op_sched     = (req_op_r == mrqs_pkg::OP_SCHEDULE);
  assign st.tid_ok       = req_ok_r;
  assign st.run_flag     = req_run_r;
  assign st.pol_rt       = (req_pol_r == '0);
  assign st.rt_hit       = rt_hit;
  assign st.pol_hit      = pol_hit;
  assign st.exp_ne       = exp_ne_r[cur_e];
  assign st.last_miss    = (miss_r == PW'(PL - 1));
  assign st.more_pol     = (cur_pol_r != POLW'(PC - 1));
  assign st.head_eq_tail = (head_rd_r == tail_rd_r);
  assign st.me_more      = (me_i_r < exp_cnt_r[cur_e]);
  assign st.out_free     = !out_valid_r || out_tready;

  assign out_tvalid      = out_valid_r;
  assign out_next_thread = out_next_r;
  assign out_found       = out_found_r;

endmodule

[bench/tb_multilevel_run_queue_scheduler.sv]
// Testbench for the run-queue scheduler: directed table, then random traffic checked by a predictor.
`timescale 1ns / 1ps
module tb_multilevel_run_queue_scheduler;

  localparam int SLOTS  = 64;
  localparam int LEVELS = 32;
  localparam int NQ     = 3 * LEVELS;
  localparam logic [1:0] POL_RT     = 2'd0;
  localparam logic [1:0] POL_ROUND  = 2'd1;
  localparam logic [1:0] POL_NORMAL = 2'd2;
  localparam logic [1:0] POL_BAD    = 2'd3;
  localparam logic OP_ENQ = mrqs_pkg::OP_ENQUEUE;
  localparam logic OP_SCH = mrqs_pkg::OP_SCHEDULE;
  localparam int RAND_ITEMS = 2000;
  localparam int TAIL_ITEMS = 200;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;

  multilevel_run_queue_scheduler dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  typedef struct {
    logic [5:0] next_thread;
    logic       found;
  } pick_t;

  typedef struct {
    logic       op;
    logic [5:0] tid;
    logic [1:0] pol;
    logic [4:0] pri;
    logic       running;
    bit         typed;
    logic [5:0] want_thread;
    logic       want_found;
  } row_t;

  pick_t pick_q[$];
  int    errors;
  int    accepted;
  bit    quiet;
  bit    queued[SLOTS];
  logic [5:0] last_pick;
  bit    last_found;

  // scheduler shadow state
  logic [5:0] q_head[NQ];
  logic [5:0] q_tail[NQ];
  bit         q_busy[NQ];
  logic [5:0] link[SLOTS];
  logic [4:0] t_pri[SLOTS];
  logic [1:0] t_pol[SLOTS];
  logic [5:0] exp_head[2];
  int         exp_cnt[2];
  bit         exp_busy[2];
  logic [4:0] round[2];

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int queue_index(input logic [5:0] t);
    int p;
    p = (t_pol[t] > POL_NORMAL) ? 2 : int'(t_pol[t]);
    return p * LEVELS + int'(t_pri[t]);
  endfunction

  function automatic void append_thread(input logic [5:0] t);
    int q;
    q = queue_index(t);
    if (q_busy[q]) begin
      link[q_tail[q]] = t;
      q_tail[q] = t;
    end else begin
      q_head[q] = t;
      q_tail[q] = t;
      q_busy[q] = 1'b1;
    end
  endfunction

  function automatic logic [5:0] pop_thread(input int q);
    logic [5:0] t;
    t = q_head[q];
    if (q_head[q] == q_tail[q]) q_busy[q] = 1'b0;
    else q_head[q] = link[t];
    return t;
  endfunction

  function automatic int find_queue(input int pol);
    for (int p = LEVELS - 1; p >= 0; p--) begin
      if (pol == 1 && int'(round[0]) > p) continue;
      if (q_busy[pol * LEVELS + p]) return pol * LEVELS + p;
    end
    return -1;
  endfunction

  function automatic void drain_expired(input int e);
    logic [5:0] cur;
    logic [5:0] nxt;
    cur = exp_head[e];
    for (int i = 0; i < exp_cnt[e]; i++) begin
      nxt = link[cur];
      append_thread(cur);
      cur = nxt;
    end
    exp_busy[e] = 1'b0;
    exp_cnt[e] = 0;
  endfunction

  function automatic void scheduler_reset();
    for (int i = 0; i < NQ; i++) begin
      q_head[i] = '0; q_tail[i] = '0; q_busy[i] = 1'b0;
    end
    for (int i = 0; i < SLOTS; i++) begin
      link[i] = '0; t_pri[i] = '0; t_pol[i] = '0;
    end
    for (int e = 0; e < 2; e++) begin
      exp_head[e] = '0; exp_cnt[e] = 0; exp_busy[e] = 1'b0; round[e] = 5'd31;
    end
  endfunction

  // returns 1 when the transaction yields a pick
  function automatic bit schedule_step(input row_t r, output pick_t res);
    logic [1:0] pol;
    int e;
    int q;
    int misses;
    pol = (r.pol > POL_NORMAL) ? POL_NORMAL : r.pol;
    res.next_thread = '0;
    res.found = 1'b0;
    if (r.op == OP_ENQ) begin
      t_pol[r.tid] = pol;
      t_pri[r.tid] = r.pri;
      append_thread(r.tid);
      return 1'b0;
    end
    if (r.running) begin
      t_pol[r.tid] = pol;
      t_pri[r.tid] = r.pri;
      if (pol == POL_RT) append_thread(r.tid);
      else begin
        e = int'(pol) - 1;
        if (exp_busy[e]) link[r.tid] = exp_head[e];
        exp_head[e] = r.tid;
        exp_busy[e] = 1'b1;
        if (exp_cnt[e] < SLOTS) exp_cnt[e]++;
      end
    end
    for (int p = LEVELS - 1; p >= 0; p--) begin
      if (q_busy[p]) begin
        res.next_thread = pop_thread(p);
        res.found = 1'b1;
        return 1'b1;
      end
    end
    for (int pl = 1; pl < 3; pl++) begin
      e = pl - 1;
      misses = 0;
      forever begin
        q = find_queue(pl);
        if (q >= 0) begin
          res.next_thread = pop_thread(q);
          res.found = 1'b1;
          return 1'b1;
        end
        round[e] = (round[e] == 0) ? 5'd31 : round[e] - 5'd1;
        if (exp_busy[e]) begin
          drain_expired(e);
          continue;
        end
        misses++;
        if (misses >= LEVELS) break;
      end
    end
    return 1'b1;
  endfunction

  task automatic send_item(input row_t r, input bit stay_busy);
    pick_t res;
    in_tvalid <= 1'b1;
    in_tuser  <= r.op;
    in_tdata  <= {2'b00, r.running, r.pri, r.pol, r.tid};
    do @(posedge clk); while (!in_tready);
    accepted++;
    if (schedule_step(r, res)) begin
      if (r.typed) begin
        res.next_thread = r.want_thread;
        res.found = r.want_found;
      end
      pick_q.push_back(res);
      last_found = res.found;
      last_pick = res.next_thread;
      if (res.found) queued[res.next_thread] = 1'b0;
    end
    if (r.op == OP_ENQ || r.running) queued[r.tid] = 1'b1;
    if (!stay_busy) in_tvalid <= 1'b0;
  endtask

  task automatic sender_gap();
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      n = $urandom_range(1, 7);
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic row_t random_item();
    row_t r;
    int busy;
    r.typed = 1'b0;
    r.want_thread = '0;
    r.want_found = 1'b0;
    busy = 0;
    foreach (queued[i]) busy += queued[i];
    r.op = ($urandom_range(0, 99) < (busy > 40 ? 25 : 55)) ? OP_ENQ : OP_SCH;
    r.pol = $urandom_range(0, 99) < 5 ? POL_BAD : 2'($urandom_range(0, 2));
    r.pri = 5'($urandom_range(0, 31));
    r.running = 1'($urandom_range(0, 1));
    r.tid = 6'($urandom_range(0, SLOTS - 1));
    if (r.op == OP_ENQ) begin
      for (int k = 0; k < 8 && queued[r.tid] && $urandom_range(0, 9) != 0; k++)
        r.tid = 6'($urandom_range(0, SLOTS - 1));
    end else if (last_found && $urandom_range(0, 9) < 8) begin
      r.tid = last_pick;
      r.running = $urandom_range(0, 9) < 7;
    end else if (queued[r.tid] && $urandom_range(0, 9) != 0) begin
      r.running = 1'b0;
    end
    return r;
  endfunction

  row_t directed[] = '{
    '{OP_SCH, 6'd0,  POL_RT,     5'd0,  1'b0, 1'b1, 6'd0,  1'b0},
    '{OP_ENQ, 6'd5,  POL_RT,     5'd31, 1'b0, 1'b0, 6'd0,  1'b0},
    '{OP_SCH, 6'd0,  POL_RT,     5'd0,  1'b0, 1'b1, 6'd5,  1'b1},
    '{OP_ENQ, 6'd63, POL_BAD,    5'd0,  1'b0, 1'b0, 6'd0,  1'b0},
    '{OP_ENQ, 6'd0,  POL_ROUND,  5'd0,  1'b0, 1'b0, 6'd0,  1'b0},
    '{OP_ENQ, 6'd42, POL_ROUND,  5'd31, 1'b0, 1'b0, 6'd0,  1'b0},
    '{OP_ENQ, 6'd21, POL_RT,     5'd21, 1'b0, 1'b0, 6'd0,  1'b0},
    '{OP_SCH, 6'd5,  POL_RT,     5'd31, 1'b1, 1'b1, 6'd5,  1'b1},
    '{OP_SCH, 6'd5,  POL_RT,     5'd10, 1'b0, 1'b1, 6'd21, 1'b1},
    '{OP_SCH, 6'd21, POL_RT,     5'd10, 1'b0, 1'b1, 6'd42, 1'b1},
    '{OP_SCH, 6'd42, POL_ROUND,  5'd31, 1'b0, 1'b0, 6'd0,  1'b0},
    '{OP_SCH, 6'd0,  POL_ROUND,  5'd0,  1'b0, 1'b0, 6'd0,  1'b0},
    '{OP_SCH, 6'd63, POL_NORMAL, 5'd7,  1'b1, 1'b0, 6'd0,  1'b0},
    '{OP_SCH, 6'd63, POL_NORMAL, 5'd7,  1'b1, 1'b0, 6'd0,  1'b0},
    '{OP_SCH, 6'd42, POL_ROUND,  5'd16, 1'b1, 1'b0, 6'd0,  1'b0},
    '{OP_ENQ, 6'd42, POL_ROUND,  5'd16, 1'b0, 1'b0, 6'd0,  1'b0},
    '{OP_SCH, 6'd42, POL_ROUND,  5'd16, 1'b0, 1'b0, 6'd0,  1'b0},
    '{OP_SCH, 6'd0,  POL_RT,     5'd0,  1'b0, 1'b0, 6'd0,  1'b0},
    '{OP_SCH, 6'd0,  POL_RT,     5'd0,  1'b0, 1'b1, 6'd0,  1'b0}
  };

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    errors     = 0;
    accepted   = 0;
    quiet      = 1'b0;
    last_found = 1'b0;
    last_pick  = '0;
    foreach (queued[i]) queued[i] = 1'b0;
    scheduler_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) begin
      send_item(directed[i], 1'b1);
      sender_gap();
    end
    for (int i = 0; i < RAND_ITEMS; i++) begin
      quiet = (i >= RAND_ITEMS - TAIL_ITEMS);
      send_item(random_item(), 1'b1);
      sender_gap();
    end
    in_tvalid <= 1'b0;
    while (pick_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (pick_q.size() != 0) report("leftover picks", pick_q.size(), 0);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // receiver: random stall bursts, one long hold to back up the input
  initial begin
    int n;
    bit held;
    held = 1'b0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!held && accepted >= 400) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (600) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 7);
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pick_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pick_q.size() == 0) report("unexpected transaction", out_tdata, 0);
      else begin
        want = pick_q.pop_front();
        if (out_tdata[5:0] != want.next_thread)
          report("next_thread", out_tdata[5:0], want.next_thread);
        if (out_tdata[6] != want.found) report("found", out_tdata[6], want.found);
        if (out_tdata[7] != 1'b0) report("pad bit", out_tdata[7], 0);
      end
    end
  end

  initial begin
    #200ms;
    $display("FAIL");
    $finish;
  end

endmodule

[multilevel_run_queue_scheduler.f]
+incdir+hw/rtl
hw/rtl/mrqs_pkg.sv
hw/rtl/mrqs_ctrl.sv
hw/rtl/mrqs_datapath.sv
hw/rtl/multilevel_run_queue_scheduler.sv
bench/tb_multilevel_run_queue_scheduler.sv
